### design/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg: shared types and codes for the KMP substring search block
// Transfer payloads on both channels, command codes and the decoded queue
// entry that passes from the front end to the search engine.
// ----------------------------------------------------------------------------
package kss_pkg;

    // Command codes carried in the request cmd field
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_TEXT   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // Request transfer payload
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       last;
    } kss_req_t;

    // Response transfer payload
    typedef struct packed {
        logic        found;
        logic [15:0] position;
    } kss_rsp_t;

    // Decoded operation held in the front-end queue (kind bits are one-hot)
    typedef struct packed {
        logic       append;
        logic       start;
        logic       text;
        logic       clear;
        logic [7:0] data_byte;
        logic       last;
    } kss_op_t;

endpackage

### design/kss_front.sv
// ----------------------------------------------------------------------------
// kss_front: request decode and two-entry command queue
// Accepts request transfers, decodes the command into a one-hot operation
// and queues it so the engine and the requester stall independently.
// ----------------------------------------------------------------------------
module kss_front
    import kss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  kss_req_t req,
    output logic     q_valid,
    output kss_op_t  q_op,
    input  logic     q_pop
);

    kss_op_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    kss_op_t    op_dec;

    // Command decode; last only matters for text bytes
    always_comb
    begin
        op_dec           = '0;
        op_dec.data_byte = req.data_byte;
        unique case (req.cmd)
            CMD_APPEND: op_dec.append = 1'b1;
            CMD_START:  op_dec.start  = 1'b1;
            CMD_TEXT:
            begin
                op_dec.text = 1'b1;
                op_dec.last = req.last;
            end
            CMD_CLEAR:  op_dec.clear  = 1'b1;
        endcase
    end

    // Queue control
    assign req_stall = (count_reg == 2'd2);
    assign push      = req_valid && !req_stall;
    assign q_valid   = (count_reg != 2'd0);
    assign q_op      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= op_dec;
        end
    end

endmodule

### design/kss_engine.sv
// ----------------------------------------------------------------------------
// kss_engine: pattern store, failure table and KMP sequencer
// Executes queued operations: appends pattern bytes, builds the failure table
// on start, steps the match per text byte and drives the response register.
// ----------------------------------------------------------------------------
module kss_engine
    import kss_pkg::*;
#(
    parameter int              PATTERN_MAX = 64,
    parameter longint unsigned TEXT_MAX    = 65536
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  kss_op_t  q_op,
    output logic     q_pop,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output kss_rsp_t rsp
);

    localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
    localparam int TI_W   = $clog2(TEXT_MAX);
    localparam logic [TI_W-1:0]   TI_LAST   = TI_W'(TEXT_MAX - 1);
    localparam logic [PLEN_W-1:0] PLEN_FULL = PLEN_W'(PATTERN_MAX);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BRD  = 2'd1;
    localparam logic [1:0] ST_BCMP = 2'd2;
    localparam logic [1:0] ST_TCMP = 2'd3;

    logic [1:0]        state_reg,  state_next;
    logic [PLEN_W-1:0] plen_reg,   plen_next;
    logic [PLEN_W-1:0] match_reg,  match_next;
    logic [TI_W-1:0]   tidx_reg,   tidx_next;
    logic              done_reg,   done_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [PLEN_W-1:0] i_reg,      i_next;
    logic [PLEN_W-1:0] k_reg,      k_next;
    logic [TI_W-1:0]   idx_reg,    idx_next;
    logic [7:0]        char_reg,   char_next;
    logic              last_reg,   last_next;
    kss_rsp_t          rsp_reg,    rsp_next;

    // Memories and their ports
    logic [7:0]       pat_mem  [PATTERN_MAX];
    logic [IDX_W-1:0] fail_mem [PATTERN_MAX];
    logic             pat_we;
    logic [IDX_W-1:0] pat_waddr;
    logic             fail_we;
    logic [IDX_W-1:0] fail_waddr;
    logic [IDX_W-1:0] fail_wdata;
    logic [IDX_W-1:0] pa_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       pa_q;
    logic [7:0]       pb_q;
    logic [IDX_W-1:0] fail_q;

    logic              rsp_load;
    logic              eq;
    logic [PLEN_W-1:0] k_step;
    logic [PLEN_W-1:0] j_start;
    logic [PLEN_W:0]   i_plus1;

    assign pa_addr   = i_reg[IDX_W-1:0];
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Text ops start only with the response register empty
    assign q_pop = (state_reg == ST_IDLE) && q_valid && (!q_op.text || !rsp_valid_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        plen_next      = plen_reg;
        match_next     = match_reg;
        tidx_next      = tidx_reg;
        done_next      = done_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        rsp_next       = rsp_reg;
        rsp_load       = 1'b0;
        pat_we         = 1'b0;
        pat_waddr      = plen_reg[IDX_W-1:0];
        fail_we        = 1'b0;
        fail_waddr     = IDX_W'(i_reg + 1'b1);
        fail_wdata     = '0;
        rd_addr        = k_reg[IDX_W-1:0];
        j_start        = (match_reg >= plen_reg) ? '0 : match_reg;
        i_plus1        = {1'b0, i_reg} + 1'b1;
        eq             = 1'b0;
        k_step         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    priority if (q_op.append)
                    begin
                        if (plen_reg < PLEN_FULL)
                        begin
                            pat_we    = 1'b1;
                            plen_next = plen_reg + 1'b1;
                        end
                        done_next = 1'b1;
                    end
                    else if (q_op.start)
                    begin
                        match_next = '0;
                        tidx_next  = '0;
                        done_next  = 1'b0;
                        if (plen_reg >= PLEN_W'(2))
                        begin
                            // border of a single byte is empty
                            fail_we    = 1'b1;
                            fail_waddr = IDX_W'(1);
                            fail_wdata = '0;
                            i_next     = PLEN_W'(1);
                            k_next     = '0;
                            state_next = ST_BRD;
                        end
                    end
                    else if (q_op.clear)
                    begin
                        plen_next  = '0;
                        match_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        if (!done_reg)
                        begin
                            // text byte of a live search
                            idx_next = tidx_reg;
                            if (tidx_reg != TI_LAST)
                            begin
                                tidx_next = tidx_reg + 1'b1;
                            end
                            if (plen_reg == '0)
                            begin
                                done_next         = 1'b1;
                                rsp_load          = 1'b1;
                                rsp_next.found    = 1'b1;
                                rsp_next.position = '0;
                            end
                            else
                            begin
                                k_next     = j_start;
                                rd_addr    = j_start[IDX_W-1:0];
                                char_next  = q_op.data_byte;
                                last_next  = q_op.last;
                                state_next = ST_TCMP;
                            end
                        end
                    end
                end
            end

            ST_BRD:
            begin
                // read pattern[i], pattern[k] and failure[k]
                if (i_plus1 >= {1'b0, plen_reg})
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_BCMP;
                end
            end

            ST_BCMP:
            begin
                eq = (pa_q == pb_q);
                if ((k_reg != '0) && !eq)
                begin
                    // fall back along the failure link
                    k_next  = PLEN_W'(fail_q);
                    rd_addr = fail_q;
                end
                else
                begin
                    k_step     = k_reg + PLEN_W'(eq);
                    fail_we    = 1'b1;
                    fail_wdata = k_step[IDX_W-1:0];
                    k_next     = k_step;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_BRD;
                end
            end

            ST_TCMP:
            begin
                eq = (pb_q == char_reg);
                if ((k_reg != '0) && !eq)
                begin
                    k_next  = PLEN_W'(fail_q);
                    rd_addr = fail_q;
                end
                else
                begin
                    k_step     = k_reg + PLEN_W'(eq);
                    match_next = k_step;
                    state_next = ST_IDLE;
                    if (k_step == plen_reg)
                    begin
                        done_next         = 1'b1;
                        rsp_load          = 1'b1;
                        rsp_next.found    = 1'b1;
                        rsp_next.position = 16'(idx_reg) + 16'd1 - 16'(plen_reg);
                    end
                    else if (last_reg)
                    begin
                        done_next         = 1'b1;
                        rsp_load          = 1'b1;
                        rsp_next.found    = 1'b0;
                        rsp_next.position = '0;
                    end
                end
            end
        endcase

        // Response register: load wins, a completed transfer empties it
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plen_reg      <= '0;
            match_reg     <= '0;
            tidx_reg      <= '0;
            done_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plen_reg      <= plen_next;
            match_reg     <= match_next;
            tidx_reg      <= tidx_next;
            done_reg      <= done_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working registers and response payload
    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        k_reg    <= k_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
        rsp_reg  <= rsp_next;
    end

    // Pattern store (two read ports) and failure table, registered reads
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_waddr] <= q_op.data_byte;
        end
        if (fail_we)
        begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        pa_q   <= pat_mem[pa_addr];
        pb_q   <= pat_mem[rd_addr];
        fail_q <= fail_mem[rd_addr];
    end

    // Checks
    a_tcmp_rsp_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TCMP |-> !rsp_valid_reg)
        else $error("search step running while response register is full");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> !rsp_valid_reg)
        else $error("response overwritten before transfer");

    a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= PLEN_FULL)
        else $error("pattern length beyond store depth");

    a_border_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BCMP |-> k_reg <= i_reg)
        else $error("border length not below prefix length");

    a_progress_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TCMP |-> k_reg < plen_reg)
        else $error("match progress outside pattern");

endmodule

### design/kmp_substring_search_top.sv
// ----------------------------------------------------------------------------
// kmp_substring_search_top: streaming first-match substring search (KMP)
// Request channel carries commands and bytes; response channel carries the
// single search outcome.
// ----------------------------------------------------------------------------
// Usage: send append transfers (cmd 0) to load pattern bytes, then a start
// transfer (cmd 1), then text bytes (cmd 2) with last set on the final one.
// Clear (cmd 3) empties the pattern. Appending or clearing ends a search.
// One response follows the first full match (found=1, start position) or
// the last text byte without a match (found=0); later text is dropped.
// Requests pass a two-entry queue, so the requester keeps sending, until it
// fills, while the engine works or a response waits. The engine pops the
// next operation only when idle. A text byte goes from idle to a compare state
// that repeats per fallback and loads the response on a match or last byte.
// Start builds the failure table: a read and a compare state per pattern
// byte plus fallbacks, paced by registered pattern and failure table reads.
// While a response is held by a stalling receiver, the next text byte waits
// at the head of the queue; commands ahead of it carry on, those behind it
// wait too. Reset empties the queue and the response register and sets the
// pattern length to zero; the pattern store and failure table hold no reset
// value and need no clearing pass.
// ----------------------------------------------------------------------------
module kmp_substring_search_top
    import kss_pkg::*;
#(
    parameter int              PATTERN_MAX = 64,
    parameter longint unsigned TEXT_MAX    = 65536
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  kss_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output kss_rsp_t rsp
);

    logic    q_valid;
    kss_op_t q_op;
    logic    q_pop;

    // Front end: decode and queue
    kss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop)
    );

    // Back end: pattern memories and search sequencer
    kss_engine #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
